### hdl/proj_pkg.sv
// Shared constants, request record and saturation helper for the projection setup block.
package proj_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int TAN_ITER_DEFAULT  = 16;

   localparam int XY_W     = 33;
   localparam int Z_W      = 34;
   localparam int QUO_BITS = 33;
   localparam int NUM_W    = 64;
   localparam int DEN_W    = 33;

   localparam logic [63:0] ANG_PI      = 64'd3373259426;
   localparam logic [63:0] ANG_HALF_PI = 64'd1686629713;
   localparam logic [63:0] ANG_ONE     = 64'd1073741824;

   localparam logic [29:0] ATAN_STEPS [0:29] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2
   };

   typedef struct packed {
      logic               op;
      logic signed [31:0] left_plane;
      logic signed [31:0] right_plane;
      logic signed [31:0] bottom_plane;
      logic signed [31:0] top_plane;
      logic signed [31:0] near_dist;
      logic signed [31:0] far_dist;
      logic        [17:0] fov_y;
      logic        [30:0] aspect_ratio;
   } req_type;

   // {saturated, value}: apply sign to magnitude, clamp to signed 32 bits
   function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [32:0] res;
      if (!neg) begin
         if (mag > 64'h0000_0000_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
         else res = {1'b0, mag[31:0]};
      end else begin
         if (mag > 64'h0000_0000_8000_0000) res = {1'b1, 32'h8000_0000};
         else res = {1'b0, 32'd0 - mag[31:0]};
      end
      return res;
   endfunction

endpackage

### hdl/proj_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating signed result.
module proj_div
   import proj_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic                in_neg,
   input  logic [NUM_W-1:0]    in_num,
   input  logic [DEN_W-1:0]    in_den,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic signed [31:0]  out_quo,
   output logic                out_fault,
   output logic [SIDE_W-1:0]   out_side
);

   logic                valid_ff [0:QUO_BITS];
   logic                neg_ff   [0:QUO_BITS];
   logic                zero_ff  [0:QUO_BITS];
   logic                ovf_ff   [0:QUO_BITS];
   logic [SIDE_W-1:0]   side_ff  [0:QUO_BITS];
   logic [DEN_W-1:0]    rem_ff   [0:QUO_BITS];
   logic [QUO_BITS-1:0] low_ff   [0:QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff   [0:QUO_BITS];
   logic [DEN_W-1:0]    den_ff   [0:QUO_BITS];

   logic [DEN_W-1:0]    rem_in   [1:QUO_BITS];
   logic [QUO_BITS-1:0] quo_in   [1:QUO_BITS];

   logic                out_valid_ff;
   logic signed [31:0]  out_quo_ff;
   logic                out_fault_ff;
   logic [SIDE_W-1:0]   out_side_ff;
   logic [32:0]         sat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         neg_ff[0]  <= in_neg;
         zero_ff[0] <= (in_den == '0);
         ovf_ff[0]  <= (in_num >> QUO_BITS) >= NUM_W'(in_den);
         side_ff[0] <= in_side;
         rem_ff[0]  <= DEN_W'(in_num >> QUO_BITS);
         low_ff[0]  <= in_num[QUO_BITS-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
      end
   end

   for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;

      always_comb begin
         trial     = {rem_ff[j-1], low_ff[j-1][QUO_BITS-j]};
         ge        = trial >= {1'b0, den_ff[j-1]};
         rem_in[j] = ge ? DEN_W'(trial - {1'b0, den_ff[j-1]}) : trial[DEN_W-1:0];
         quo_in[j] = {quo_ff[j-1][QUO_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         if (advance) begin
            neg_ff[j]  <= neg_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
            ovf_ff[j]  <= ovf_ff[j-1];
            side_ff[j] <= side_ff[j-1];
            rem_ff[j]  <= rem_in[j];
            low_ff[j]  <= low_ff[j-1];
            quo_ff[j]  <= quo_in[j];
            den_ff[j]  <= den_ff[j-1];
         end
      end
   end

   assign sat_in = sat_mag(neg_ff[QUO_BITS], 64'(quo_ff[QUO_BITS]));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[QUO_BITS];
      end
      if (advance) begin
         out_side_ff <= side_ff[QUO_BITS];
         if (zero_ff[QUO_BITS]) begin
            out_quo_ff   <= '0;
            out_fault_ff <= 1'b1;
         end else if (ovf_ff[QUO_BITS]) begin
            out_quo_ff   <= neg_ff[QUO_BITS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            out_fault_ff <= 1'b1;
         end else begin
            out_quo_ff   <= $signed(sat_in[31:0]);
            out_fault_ff <= sat_in[32];
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = out_quo_ff;
   assign out_fault = out_fault_ff;
   assign out_side  = out_side_ff;

endmodule

### hdl/proj_tan.sv
// Angle reduction and pipelined CORDIC rotation: gain-scaled cosine and sine of half FOV mod pi.
module proj_tan
   import proj_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEFAULT,
   parameter int TAN_ITERATIONS = TAN_ITER_DEFAULT,
   parameter int SIDE_W         = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [17:0]            in_fov,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic signed [XY_W-1:0] out_x,
   output logic signed [XY_W-1:0] out_y,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int UP        = (FRAC_BITS <= 29) ? 29 - FRAC_BITS : 0;
   localparam int DN        = (FRAC_BITS > 29) ? FRAC_BITS - 29 : 0;
   localparam int ANG_W     = 47 - FRAC_BITS;
   localparam int RED_STEPS = (ANG_W > 32) ? ANG_W - 31 : 1;
   localparam int RED_W     = (ANG_W > 32) ? ANG_W : 32;

   logic [RED_W-1:0]      red_ff [0:RED_STEPS];
   logic                  rv_ff  [0:RED_STEPS];
   logic [SIDE_W-1:0]     rs_ff  [0:RED_STEPS];
   logic [RED_W-1:0]      red_in [1:RED_STEPS];

   logic signed [XY_W-1:0] cx_ff [0:TAN_ITERATIONS];
   logic signed [XY_W-1:0] cy_ff [0:TAN_ITERATIONS];
   logic signed [Z_W-1:0]  cz_ff [0:TAN_ITERATIONS];
   logic                   cv_ff [0:TAN_ITERATIONS];
   logic [SIDE_W-1:0]      cs_ff [0:TAN_ITERATIONS];
   logic signed [XY_W-1:0] cx_in [1:TAN_ITERATIONS];
   logic signed [XY_W-1:0] cy_in [1:TAN_ITERATIONS];
   logic signed [Z_W-1:0]  cz_in [1:TAN_ITERATIONS];

   logic [RED_W-1:0]       ang_in;
   logic signed [Z_W-1:0]  fold_in;
   logic signed [Z_W-1:0]  red_z;

   assign ang_in = RED_W'((48'(in_fov) << UP) >> DN);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (advance) begin
         rv_ff[0] <= in_valid;
      end
      if (advance) begin
         red_ff[0] <= ang_in;
         rs_ff[0]  <= in_side;
      end
   end

   for (genvar r = 1; r <= RED_STEPS; r++) begin : g_red
      localparam logic [RED_W-1:0] PI_K = RED_W'(ANG_PI << (RED_STEPS - r));

      assign red_in[r] = (red_ff[r-1] >= PI_K) ? red_ff[r-1] - PI_K : red_ff[r-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[r] <= 1'b0;
         end else if (advance) begin
            rv_ff[r] <= rv_ff[r-1];
         end
         if (advance) begin
            red_ff[r] <= red_in[r];
            rs_ff[r]  <= rs_ff[r-1];
         end
      end
   end

   always_comb begin
      red_z = $signed({2'b00, red_ff[RED_STEPS][31:0]});
      if (red_z > $signed(Z_W'(ANG_HALF_PI))) begin
         fold_in = red_z - $signed(Z_W'(ANG_PI));
      end else begin
         fold_in = red_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (advance) begin
         cv_ff[0] <= rv_ff[RED_STEPS];
      end
      if (advance) begin
         cx_ff[0] <= $signed(XY_W'(ANG_ONE));
         cy_ff[0] <= '0;
         cz_ff[0] <= fold_in;
         cs_ff[0] <= rs_ff[RED_STEPS];
      end
   end

   for (genvar i = 1; i <= TAN_ITERATIONS; i++) begin : g_rot
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [Z_W-1:0]  step;

      always_comb begin
         xs   = cx_ff[i-1] >>> (i - 1);
         ys   = cy_ff[i-1] >>> (i - 1);
         step = $signed({4'b0000, ATAN_STEPS[i-1]});
         if (cz_ff[i-1] >= 0) begin
            cx_in[i] = cx_ff[i-1] - ys;
            cy_in[i] = cy_ff[i-1] + xs;
            cz_in[i] = cz_ff[i-1] - step;
         end else begin
            cx_in[i] = cx_ff[i-1] + ys;
            cy_in[i] = cy_ff[i-1] - xs;
            cz_in[i] = cz_ff[i-1] + step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (advance) begin
            cv_ff[i] <= cv_ff[i-1];
         end
         if (advance) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
            cs_ff[i] <= cs_ff[i-1];
         end
      end
   end

   assign out_valid = cv_ff[TAN_ITERATIONS];
   assign out_x     = cx_ff[TAN_ITERATIONS];
   assign out_y     = cy_ff[TAN_ITERATIONS];
   assign out_side  = cs_ff[TAN_ITERATIONS];

endmodule

### hdl/perspective_projection_setup.sv
// Top level of the perspective projection setup pipeline.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  op, six planes, fov_y, aspect_ratio
//   rsp_      out        rsp_valid / rsp_stall  six matrix entries, divide_fault
//
// One request per cycle while the response is not stalled.
// The path runs through the angle reduction steps, the CORDIC stages, one divider and then
// six dividers in parallel.
// RED_STEPS is 1 for FRAC_BITS of 15 or more, else 16 - FRAC_BITS.
// Reset clears the valid bits only. A stalled response freezes the whole pipeline.
module perspective_projection_setup
   import proj_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEFAULT,
   parameter int TAN_ITERATIONS = TAN_ITER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic signed [31:0] req_left_plane,
   input  logic signed [31:0] req_right_plane,
   input  logic signed [31:0] req_bottom_plane,
   input  logic signed [31:0] req_top_plane,
   input  logic signed [31:0] req_near_dist,
   input  logic signed [31:0] req_far_dist,
   input  logic        [17:0] req_fov_y,
   input  logic        [30:0] req_aspect_ratio,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_scale_x,
   output logic signed [31:0] rsp_scale_y,
   output logic signed [31:0] rsp_offset_x,
   output logic signed [31:0] rsp_offset_y,
   output logic signed [31:0] rsp_depth_scale,
   output logic signed [31:0] rsp_depth_offset,
   output logic               rsp_divide_fault
);

   localparam int REQ_W = $bits(req_type);

   logic       advance;
   req_type    req_in;

   logic                   tan_valid;
   logic signed [XY_W-1:0] tan_x;
   logic signed [XY_W-1:0] tan_y;
   logic [REQ_W-1:0]       tan_side;
   req_type                tan_req;

   logic             m1_valid_ff;
   logic             m1_neg_ff;
   logic [63:0]      m1_num_ff;
   logic [DEN_W-1:0] m1_den_ff;
   req_type          m1_req_ff;
   logic             m1_neg_in;
   logic [63:0]      m1_num_in;
   logic [DEN_W-1:0] m1_den_in;
   logic [31:0]      m1_mag_n;
   logic [31:0]      m1_mag_y;

   logic               bt_valid;
   logic signed [31:0] bt_quo;
   logic               bt_fault;
   logic [REQ_W-1:0]   bt_side;
   req_type            bt_req;

   logic               m2_valid_ff;
   logic [62:0]        m2_prod_ff;
   logic signed [31:0] m2_bt_ff;
   logic               m2_fault_ff;
   req_type            m2_req_ff;
   logic [31:0]        m2_mag_bt;
   logic [62:0]        m2_prod_in;

   logic               m3_valid_ff;
   logic signed [31:0] m3_lr_ff;
   logic signed [31:0] m3_bt_ff;
   logic               m3_fault_ff;
   req_type            m3_req_ff;
   logic [32:0]        m3_sat_in;

   logic             p_valid_ff;
   logic [63:0]      p_num_ff   [0:5];
   logic [DEN_W-1:0] p_den_ff   [0:5];
   logic             p_neg_ff   [0:5];
   logic             p_fault_ff;
   logic [63:0]      p_num_in   [0:5];
   logic [DEN_W-1:0] p_den_in   [0:5];
   logic             p_neg_in   [0:5];
   logic             p_fault_in;

   logic signed [33:0] pl, pr, pb, pt, dx, sx, dy, sy;
   logic signed [32:0] dz, sz;
   logic signed [31:0] pn, pf;
   logic [32:0]        mag_dx, mag_sx, mag_dy, mag_sy, mag_dz, mag_sz;
   logic [31:0]        mag_n, mag_f;
   logic [62:0]        fn_prod;

   logic [5:0]         fr_valid;
   logic [5:0]         fr_fault;
   logic [5:0]         fr_side;
   logic signed [31:0] fr_quo [0:5];

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_quo_ff [0:5];
   logic               rsp_fault_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign req_in = '{
      op:           req_op,
      left_plane:   req_left_plane,
      right_plane:  req_right_plane,
      bottom_plane: req_bottom_plane,
      top_plane:    req_top_plane,
      near_dist:    req_near_dist,
      far_dist:     req_far_dist,
      fov_y:        req_fov_y,
      aspect_ratio: req_aspect_ratio
   };

   proj_tan #(
      .FRAC_BITS      (FRAC_BITS),
      .TAN_ITERATIONS (TAN_ITERATIONS),
      .SIDE_W         (REQ_W)
   ) u_tan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_fov    (req_fov_y),
      .in_side   (req_in),
      .out_valid (tan_valid),
      .out_x     (tan_x),
      .out_y     (tan_y),
      .out_side  (tan_side)
   );

   always_comb begin
      tan_req   = req_type'(tan_side);
      m1_mag_n  = tan_req.near_dist[31] ? 32'd0 - tan_req.near_dist : tan_req.near_dist;
      m1_mag_y  = 32'(tan_y[XY_W-1] ? -tan_y : tan_y);
      m1_den_in = DEN_W'(tan_x[XY_W-1] ? -tan_x : tan_x);
      m1_neg_in = tan_req.near_dist[31] ^ tan_y[XY_W-1] ^ tan_x[XY_W-1];
      m1_num_in = m1_mag_n * m1_mag_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= tan_valid;
      end
      if (advance) begin
         m1_neg_ff <= m1_neg_in;
         m1_num_ff <= m1_num_in;
         m1_den_ff <= m1_den_in;
         m1_req_ff <= tan_req;
      end
   end

   proj_div #(
      .SIDE_W (REQ_W)
   ) u_div_bt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m1_valid_ff),
      .in_neg    (m1_neg_ff),
      .in_num    (m1_num_ff),
      .in_den    (m1_den_ff),
      .in_side   (m1_req_ff),
      .out_valid (bt_valid),
      .out_quo   (bt_quo),
      .out_fault (bt_fault),
      .out_side  (bt_side)
   );

   always_comb begin
      bt_req     = req_type'(bt_side);
      m2_mag_bt  = bt_quo[31] ? 32'd0 - bt_quo : bt_quo;
      m2_prod_in = m2_mag_bt * bt_req.aspect_ratio;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= bt_valid;
      end
      if (advance) begin
         m2_prod_ff  <= m2_prod_in;
         m2_bt_ff    <= bt_quo;
         m2_fault_ff <= bt_fault;
         m2_req_ff   <= bt_req;
      end
   end

   assign m3_sat_in = sat_mag(m2_bt_ff[31], 64'(m2_prod_ff >> FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (advance) begin
         m3_valid_ff <= m2_valid_ff;
      end
      if (advance) begin
         m3_lr_ff    <= $signed(m3_sat_in[31:0]);
         m3_bt_ff    <= m2_bt_ff;
         m3_fault_ff <= m2_fault_ff | m3_sat_in[32];
         m3_req_ff   <= m2_req_ff;
      end
   end

   always_comb begin
      pn = m3_req_ff.near_dist;
      pf = m3_req_ff.far_dist;
      if (m3_req_ff.op) begin
         pr         = 34'(m3_lr_ff);
         pl         = -pr;
         pt         = 34'(m3_bt_ff);
         pb         = -pt;
         p_fault_in = m3_fault_ff;
      end else begin
         pl         = 34'(m3_req_ff.left_plane);
         pr         = 34'(m3_req_ff.right_plane);
         pb         = 34'(m3_req_ff.bottom_plane);
         pt         = 34'(m3_req_ff.top_plane);
         p_fault_in = 1'b0;
      end
      dx = pr - pl;
      sx = pr + pl;
      dy = pt - pb;
      sy = pt + pb;
      dz = 33'(pf) - 33'(pn);
      sz = 33'(pf) + 33'(pn);
      mag_dx  = 33'(dx[33] ? -dx : dx);
      mag_sx  = 33'(sx[33] ? -sx : sx);
      mag_dy  = 33'(dy[33] ? -dy : dy);
      mag_sy  = 33'(sy[33] ? -sy : sy);
      mag_dz  = 33'(dz[32] ? -dz : dz);
      mag_sz  = 33'(sz[32] ? -sz : sz);
      mag_n   = pn[31] ? 32'd0 - pn : pn;
      mag_f   = pf[31] ? 32'd0 - pf : pf;
      fn_prod = mag_f * mag_n;

      p_num_in[0] = 64'({mag_n, 1'b0}) << FRAC_BITS;
      p_den_in[0] = mag_dx;
      p_neg_in[0] = pn[31] ^ dx[33];
      p_num_in[1] = 64'({mag_n, 1'b0}) << FRAC_BITS;
      p_den_in[1] = mag_dy;
      p_neg_in[1] = pn[31] ^ dy[33];
      p_num_in[2] = 64'(mag_sx) << FRAC_BITS;
      p_den_in[2] = mag_dx;
      p_neg_in[2] = sx[33] ^ dx[33];
      p_num_in[3] = 64'(mag_sy) << FRAC_BITS;
      p_den_in[3] = mag_dy;
      p_neg_in[3] = sy[33] ^ dy[33];
      p_num_in[4] = 64'(mag_sz) << FRAC_BITS;
      p_den_in[4] = mag_dz;
      p_neg_in[4] = ~(sz[32] ^ dz[32]);
      p_num_in[5] = {fn_prod, 1'b0};
      p_den_in[5] = mag_dz;
      p_neg_in[5] = ~(pf[31] ^ pn[31] ^ dz[32]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= m3_valid_ff;
      end
      if (advance) begin
         p_num_ff   <= p_num_in;
         p_den_ff   <= p_den_in;
         p_neg_ff   <= p_neg_in;
         p_fault_ff <= p_fault_in;
      end
   end

   for (genvar k = 0; k < 6; k++) begin : g_frustum
      proj_div #(
         .SIDE_W (1)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (p_valid_ff),
         .in_neg    (p_neg_ff[k]),
         .in_num    (p_num_ff[k]),
         .in_den    (p_den_ff[k]),
         .in_side   (p_fault_ff),
         .out_valid (fr_valid[k]),
         .out_quo   (fr_quo[k]),
         .out_fault (fr_fault[k]),
         .out_side  (fr_side[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= &fr_valid;
      end
      if (advance) begin
         rsp_quo_ff   <= fr_quo;
         rsp_fault_ff <= (|fr_side) | (|fr_fault);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scale_x      = rsp_quo_ff[0];
   assign rsp_scale_y      = rsp_quo_ff[1];
   assign rsp_offset_x     = rsp_quo_ff[2];
   assign rsp_offset_y     = rsp_quo_ff[3];
   assign rsp_depth_scale  = rsp_quo_ff[4];
   assign rsp_depth_offset = rsp_quo_ff[5];
   assign rsp_divide_fault = rsp_fault_ff;

endmodule

### hdl/proj_check.sv
// Port-level checks on the projection setup block, bound to its top level.
module proj_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_op,
   input logic signed [31:0] req_left_plane,
   input logic signed [31:0] req_right_plane,
   input logic signed [31:0] req_bottom_plane,
   input logic signed [31:0] req_top_plane,
   input logic signed [31:0] req_near_dist,
   input logic signed [31:0] req_far_dist,
   input logic        [17:0] req_fov_y,
   input logic        [30:0] req_aspect_ratio,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_scale_x,
   input logic signed [31:0] rsp_scale_y,
   input logic signed [31:0] rsp_offset_x,
   input logic signed [31:0] rsp_offset_y,
   input logic signed [31:0] rsp_depth_scale,
   input logic signed [31:0] rsp_depth_offset,
   input logic               rsp_divide_fault
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scale_x)
         && $stable(rsp_scale_y) && $stable(rsp_offset_x) && $stable(rsp_offset_y)
         && $stable(rsp_depth_scale) && $stable(rsp_depth_offset)
         && $stable(rsp_divide_fault))
      else $error("stalled response changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   a_stall_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while pipeline frozen");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind perspective_projection_setup proj_check u_proj_check (.*);
